// File: hdl/tbd_pkg.sv
// Shared types, event codes and timing helpers for the two-button debounce block.
// No dependencies; imported by tbd_button and the top level.
package tbd_pkg;

   localparam int TimeWidth = 16;
   localparam int CfgWidth  = 15;
   localparam int CsrIndexWidth = 2;

   localparam logic [CfgWidth-1:0] DebounceReset    = 15'd10;
   localparam logic [CfgWidth-1:0] LongPressReset   = 15'd2000;
   localparam logic [CfgWidth-1:0] IdleTimeoutReset = 15'd25000;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_DEBOUNCE     = 2'd0,
      CSR_LONG_PRESS   = 2'd1,
      CSR_IDLE_TIMEOUT = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      EV_NONE    = 4'd0,
      EV_TIMEOUT = 4'd1,
      EV_BOTH    = 4'd2,
      EV_A_UP    = 4'd3,
      EV_B_UP    = 4'd4,
      EV_A_DOWN  = 4'd5,
      EV_B_DOWN  = 4'd6,
      EV_A_LONG  = 4'd7,
      EV_B_LONG  = 4'd8
   } event_code_type;

   // per-button event kind, mapped to A or B codes at the top level
   typedef enum logic [2:0] {
      BEV_NONE,
      BEV_UP,
      BEV_DOWN,
      BEV_BOTH,
      BEV_LONG
   } button_event_type;

   typedef struct packed {
      logic                 raw_level;
      logic                 settling;
      logic                 held;
      logic                 long_reported;
      logic [TimeWidth-1:0] change_time;
   } button_state_type;

   // magnitude of the signed wrapped difference, 0..32768
   function automatic logic [TimeWidth-1:0] elapsed(input logic [TimeWidth-1:0] now,
                                                    input logic [TimeWidth-1:0] then);
      logic [TimeWidth-1:0] d;
      d = now - then;
      return d[TimeWidth-1] ? (~d + 1'b1) : d;
   endfunction

endpackage

// File: hdl/tbd_button.sv
// Debounce and long-press logic for one button, purely combinational.
// Depends on tbd_pkg for the state struct, event kinds and elapsed().
module tbd_button (
   input  logic                             level,
   input  logic [tbd_pkg::TimeWidth-1:0]    ms_now,
   input  tbd_pkg::button_state_type        state_cur,
   input  logic                             other_held,
   input  logic                             last_was_both,
   input  logic [tbd_pkg::CfgWidth-1:0]     debounce_ms,
   input  logic [tbd_pkg::CfgWidth-1:0]     long_press_ms,
   output tbd_pkg::button_state_type        state_nxt,
   output tbd_pkg::button_event_type        event_kind
);
   import tbd_pkg::*;

   logic [TimeWidth-1:0] since_change;

   assign since_change = elapsed(ms_now, state_cur.change_time);

   always_comb begin
      state_nxt  = state_cur;
      event_kind = BEV_NONE;
      if (level != state_cur.raw_level) begin
         state_nxt.settling    = 1'b1;
         state_nxt.change_time = ms_now;
         state_nxt.raw_level   = level;
      end else if (state_cur.settling && since_change > {1'b0, debounce_ms}) begin
         state_nxt.settling = 1'b0;
         if (state_cur.raw_level != state_cur.held) begin
            state_nxt.held = state_cur.raw_level;
            if (!state_cur.raw_level) begin
               // release is silent after a long press or a both-pressed event
               if (!state_cur.long_reported && !last_was_both) begin
                  event_kind = BEV_UP;
               end
               state_nxt.long_reported = 1'b0;
            end else if (other_held) begin
               event_kind = BEV_BOTH;
            end else begin
               event_kind = BEV_DOWN;
            end
         end
      end else if (state_cur.held) begin
         if (since_change >= {1'b0, long_press_ms} && !state_cur.long_reported) begin
            state_nxt.long_reported = 1'b1;
            event_kind = BEV_LONG;
         end
      end
   end

endmodule

// File: hdl/two_button_debounce_long_press_top.sv
// Each accepted sample's event is registered and appears on rsp_tdata in the next cycle.
// Throughput: one sample per clock while rsp_tready keeps the output free; all state updates in the same cycle.
// The output register parts the sides: req_tready stays high while rsp is taken.
// Synchronous active-high reset clears button state, last event, activity time,
// and loads the register defaults (debounce 10, long press 2000, timeout 25000).
module two_button_debounce_long_press_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [23:0]                          req_tdata,  // ms_now[15:0], button_a_down[16], button_b_down[17], zero pad
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [7:0]                           rsp_tdata,  // event_res[3:0], zero pad
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tbd_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [tbd_pkg::CfgWidth-1:0]         csr_data
);
   import tbd_pkg::*;

   logic [CfgWidth-1:0]  debounce_ff, long_press_ff, idle_timeout_ff;
   button_state_type     btn_a_ff, btn_b_ff;
   button_state_type     btn_a_in, btn_b_in;
   event_code_type       last_event_ff, last_event_in;
   logic [TimeWidth-1:0] last_activity_ff, last_activity_in;
   logic                 rsp_valid_ff;
   event_code_type       rsp_event_ff, event_in;

   logic [TimeWidth-1:0] ms_now;
   logic                 level_a, level_b;
   button_event_type     kind_a, kind_b;
   logic                 accept;

   assign ms_now  = req_tdata[15:0];
   assign level_a = req_tdata[16];
   assign level_b = req_tdata[17];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_event_ff};

   tbd_button u_button_a (
      .level         (level_a),
      .ms_now        (ms_now),
      .state_cur     (btn_a_ff),
      .other_held    (btn_b_ff.held),
      .last_was_both (last_event_ff == EV_BOTH),
      .debounce_ms   (debounce_ff),
      .long_press_ms (long_press_ff),
      .state_nxt     (btn_a_in),
      .event_kind    (kind_a)
   );

   // B sees A's held level as updated in this same sample
   tbd_button u_button_b (
      .level         (level_b),
      .ms_now        (ms_now),
      .state_cur     (btn_b_ff),
      .other_held    (btn_a_in.held),
      .last_was_both (last_event_ff == EV_BOTH),
      .debounce_ms   (debounce_ff),
      .long_press_ms (long_press_ff),
      .state_nxt     (btn_b_in),
      .event_kind    (kind_b)
   );

   always_comb begin
      event_in = EV_NONE;
      case (kind_a)
         BEV_UP:   event_in = EV_A_UP;
         BEV_DOWN: event_in = EV_A_DOWN;
         BEV_BOTH: event_in = EV_BOTH;
         BEV_LONG: event_in = EV_A_LONG;
         default:  event_in = EV_NONE;
      endcase
      // B overrides A
      case (kind_b)
         BEV_UP:   event_in = EV_B_UP;
         BEV_DOWN: event_in = EV_B_DOWN;
         BEV_BOTH: event_in = EV_BOTH;
         BEV_LONG: event_in = EV_B_LONG;
         default:  ;
      endcase

      last_event_in    = last_event_ff;
      last_activity_in = last_activity_ff;
      if (event_in != EV_NONE) begin
         last_activity_in = ms_now;
         last_event_in    = event_in;
      end else if (elapsed(ms_now, last_activity_ff) >= {1'b0, idle_timeout_ff} &&
                   last_event_ff != EV_TIMEOUT) begin
         last_event_in = EV_TIMEOUT;
         event_in      = EV_TIMEOUT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff     <= DebounceReset;
         long_press_ff   <= LongPressReset;
         idle_timeout_ff <= IdleTimeoutReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DEBOUNCE:     debounce_ff     <= csr_data;
            CSR_LONG_PRESS:   long_press_ff   <= csr_data;
            CSR_IDLE_TIMEOUT: idle_timeout_ff <= csr_data;
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         btn_a_ff         <= '0;
         btn_b_ff         <= '0;
         last_event_ff    <= EV_NONE;
         last_activity_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (accept) begin
            btn_a_ff         <= btn_a_in;
            btn_b_ff         <= btn_b_in;
            last_event_ff    <= last_event_in;
            last_activity_ff <= last_activity_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_event_ff <= event_in;
      end
   end

endmodule

// File: tb/sv/debounce_event_checker.sv
// Event checker for two_button_debounce_long_press_top: watches the sample, event
// and register channels, predicts each event and compares it. Depends on tbd_pkg.
`timescale 1ns / 100ps

module debounce_event_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [23:0]                          req_tdata,  // ms_now[15:0], button_a_down[16], button_b_down[17]
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [7:0]                           rsp_tdata,  // event_res[3:0]
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [tbd_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [tbd_pkg::CfgWidth-1:0]         csr_data,
   output int                                   outstanding,
   output int                                   fail_count
);
   import tbd_pkg::*;

   logic [CfgWidth-1:0]  debounce_ms;
   logic [CfgWidth-1:0]  long_press_ms;
   logic [CfgWidth-1:0]  idle_ms;

   logic [1:0]           raw_lvl;
   logic [1:0]           settling;
   logic [1:0]           held;
   logic [1:0]           long_done;
   logic [TimeWidth-1:0] change_ms [2];
   event_code_type       last_ev;
   logic [TimeWidth-1:0] activity_ms;

   event_code_type       pending_events [$];
   int                   mismatches = 0;

   assign fail_count = mismatches;

   // |signed 16-bit wrapped difference|, range 0..32768
   function automatic logic [TimeWidth:0] wrap_gap(input logic [TimeWidth-1:0] now,
                                                    input logic [TimeWidth-1:0] then);
      logic [TimeWidth-1:0] d;
      d = now - then;
      return d[TimeWidth-1] ? (17'h10000 - {1'b0, d}) : {1'b0, d};
   endfunction

   // One poll sample: A handled before B, so B's event overrides A's.
   function automatic event_code_type predict_event(input logic [TimeWidth-1:0] now,
                                                    input logic [1:0] lvl);
      event_code_type ev;
      ev = EV_NONE;
      for (int i = 0; i < 2; i++) begin
         if (lvl[i] != raw_lvl[i]) begin
            settling[i]  = 1'b1;
            change_ms[i] = now;
            raw_lvl[i]   = lvl[i];
         end else if (settling[i] && wrap_gap(now, change_ms[i]) > debounce_ms) begin
            settling[i] = 1'b0;
            if (raw_lvl[i] != held[i]) begin
               held[i] = raw_lvl[i];
               if (!held[i]) begin
                  // release after a long press or a both-pressed is silent
                  if (!long_done[i] && last_ev != EV_BOTH)
                     ev = (i == 0) ? EV_A_UP : EV_B_UP;
                  long_done[i] = 1'b0;
               end else if (held[1-i]) begin
                  ev = EV_BOTH;
               end else begin
                  ev = (i == 0) ? EV_A_DOWN : EV_B_DOWN;
               end
            end
         end else if (held[i]) begin
            // also runs while a steady level is still settling
            if (wrap_gap(now, change_ms[i]) >= long_press_ms && !long_done[i]) begin
               long_done[i] = 1'b1;
               ev = (i == 0) ? EV_A_LONG : EV_B_LONG;
            end
         end
      end
      if (ev != EV_NONE) begin
         activity_ms = now;
         last_ev     = ev;
      end else if (wrap_gap(now, activity_ms) >= idle_ms && last_ev != EV_TIMEOUT) begin
         last_ev = EV_TIMEOUT;
         ev      = EV_TIMEOUT;
      end
      return ev;
   endfunction

   task automatic report_mismatch(input string what, input logic [3:0] got,
                                  input logic [3:0] want);
      $display("%0t ns: event mismatch: %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      event_code_type want;
      if (reset) begin
         debounce_ms   = DebounceReset;
         long_press_ms = LongPressReset;
         idle_ms       = IdleTimeoutReset;
         raw_lvl       = '0;
         settling      = '0;
         held          = '0;
         long_done     = '0;
         change_ms[0]  = '0;
         change_ms[1]  = '0;
         last_ev       = EV_NONE;
         activity_ms   = '0;
         pending_events.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEBOUNCE:     debounce_ms   = csr_data;
               CSR_LONG_PRESS:   long_press_ms = csr_data;
               CSR_IDLE_TIMEOUT: idle_ms       = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            pending_events.push_back(predict_event(req_tdata[15:0], req_tdata[17:16]));
         if (rsp_tvalid && rsp_tready) begin
            if (pending_events.size() == 0) begin
               report_mismatch("event with no sample outstanding", rsp_tdata[3:0], EV_NONE);
            end else begin
               want = pending_events.pop_front();
               if (rsp_tdata[3:0] !== want)
                  report_mismatch("event_res", rsp_tdata[3:0], want);
            end
         end
      end
      outstanding <= pending_events.size();
   end

endmodule

// File: tb/sv/two_button_debounce_long_press_top_tb.sv
// Top-level testbench for two_button_debounce_long_press_top: drives samples, register
// writes and random backpressure; debounce_event_checker predicts and compares events.
`timescale 1ns / 100ps

module two_button_debounce_long_press_top_tb;
   import tbd_pkg::*;

   localparam logic [CsrIndexWidth-1:0] CSR_SPARE = 2'd3;  // not a register, must be ignored
   localparam int WatchdogLimit = 2000;
   localparam int CalmItems     = 100;

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [23:0]              req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [7:0]               rsp_tdata;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index  = '0;
   logic [CfgWidth-1:0]      csr_data   = '0;

   int                       outstanding;
   int                       fail_count;

   bit                       calm = 1'b0;
   int                       stall_left = 0;
   int                       quiet_cycles = 0;

   // mirror of the register settings, used only to shape time steps
   int                       deb_cfg  = 10;
   int                       long_cfg = 2000;
   int                       idle_cfg = 25000;
   logic [15:0]              ms_cursor;
   logic                     goal_a;
   logic                     goal_b;

   two_button_debounce_long_press_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   debounce_event_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // event sink: drops rsp_tready in random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("[two_button_debounce_long_press_top] ERROR");
            $finish;
         end
      end
   end

   task automatic send_sample(input logic [15:0] ms, input logic a, input logic b);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tdata  <= {6'b0, b, a, ms};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off the sender until every predicted event has been taken
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx, input logic [CfgWidth-1:0] val);
      wait_drained();
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input int deb, input int lng, input int idl);
      write_csr(CSR_DEBOUNCE, CfgWidth'(deb));
      write_csr(CSR_LONG_PRESS, CfgWidth'(lng));
      write_csr(CSR_IDLE_TIMEOUT, CfgWidth'(idl));
      deb_cfg  = deb;
      long_cfg = lng;
      idle_cfg = idl;
   endtask

   // Buttons follow a slowly changing goal level with occasional one-sample bounces;
   // time steps mix tiny steps, steps near each threshold and wrap-sized jumps.
   task automatic send_random(input int count);
      logic [15:0] step;
      logic        a;
      logic        b;
      int          pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 35)
            step = 16'($urandom_range(0, 4));
         else if (pick < 65)
            step = 16'($urandom_range(0, deb_cfg + deb_cfg / 2 + 2));
         else if (pick < 80)
            step = 16'($urandom_range(0, long_cfg / 4 + long_cfg + 1));
         else if (pick < 90)
            step = 16'($urandom_range(0, idle_cfg / 3 + 1));
         else if (pick < 95)
            step = 16'($urandom);
         else
            step = 16'(16'h7FFF + $urandom_range(0, 2));
         ms_cursor = ms_cursor + step;
         if ($urandom_range(0, 11) == 0) goal_a = !goal_a;
         if ($urandom_range(0, 11) == 0) goal_b = !goal_b;
         a = goal_a ^ ($urandom_range(0, 9) == 0);
         b = goal_b ^ ($urandom_range(0, 9) == 0);
         if (!calm && $urandom_range(0, 99) == 0)
            wait_drained();
         send_sample(ms_cursor, a, b);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed walk at the reset settings
      send_sample(16'd0,     1'b0, 1'b0);
      send_sample(16'd5,     1'b1, 1'b0);
      send_sample(16'd16,    1'b1, 1'b0);  // A down
      send_sample(16'd20,    1'b1, 1'b1);
      send_sample(16'd31,    1'b1, 1'b1);  // both pressed
      send_sample(16'd2100,  1'b1, 1'b1);  // A and B long, B wins
      send_sample(16'd2110,  1'b0, 1'b0);
      send_sample(16'd2121,  1'b0, 1'b0);  // releases after long: silent
      send_sample(16'd2150,  1'b1, 1'b0);  // bounce on press
      send_sample(16'd2154,  1'b0, 1'b0);
      send_sample(16'd2158,  1'b1, 1'b0);
      send_sample(16'd2169,  1'b1, 1'b0);  // A down
      send_sample(16'd2180,  1'b0, 1'b0);
      send_sample(16'd2191,  1'b0, 1'b0);  // A up
      send_sample(16'd2200,  1'b0, 1'b1);
      send_sample(16'd2211,  1'b0, 1'b1);  // B down
      send_sample(16'd2220,  1'b0, 1'b0);
      send_sample(16'd2231,  1'b0, 1'b0);  // B up
      send_sample(16'd2240,  1'b1, 1'b0);
      send_sample(16'd2251,  1'b1, 1'b0);
      send_sample(16'd2260,  1'b1, 1'b1);
      send_sample(16'd2271,  1'b1, 1'b1);  // both pressed
      send_sample(16'd2280,  1'b0, 1'b0);
      send_sample(16'd2291,  1'b0, 1'b0);  // releases after both: silent
      send_sample(16'd27291, 1'b0, 1'b0);  // idle timeout
      send_sample(16'd27400, 1'b1, 1'b0);
      send_sample(16'd27411, 1'b1, 1'b0);
      send_sample(16'd29500, 1'b1, 1'b0);  // A long alone
      ms_cursor = 16'd29500;
      goal_a    = 1'b1;
      goal_b    = 1'b0;

      send_random(150);
      configure(0, 0, 0);
      send_random(120);
      configure(32767, 32767, 32767);
      write_csr(CSR_SPARE, CfgWidth'($urandom));
      send_random(120);
      configure(3, 60, 500);
      send_random(250);
      configure($urandom_range(0, 40), $urandom_range(0, 3000), $urandom_range(0, 20000));
      send_random(160);
      calm = 1'b1;
      send_random(CalmItems);

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("[two_button_debounce_long_press_top] OK");
      else
         $display("[two_button_debounce_long_press_top] ERROR");
      $finish;
   end

endmodule
